/* design/ale_pkg.sv */
// shared types and constants of the array list engine
// no dependencies; imported by every other file of the block but ale_ram
package ale_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int LEN_W     = 9;

	localparam logic [LEN_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [2:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_APPEND = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		status_t                   status;
		logic [LEN_W-1:0]          length_now;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_DRAIN,
		S_FINAL,
		S_GET,
		S_CAP,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic shift_rd;
		logic get_rd;
		logic get_cap;
		logic wr_val;
		logic wr_at_len;
		logic len_inc;
		logic len_dec;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		status_t status;
		logic    shift_need;
		logic    shift_last;
	} dp_sts_t;

endpackage

/* design/array_list_engine.sv */
// array list engine: get, set, append, insert and delete on a list in ram
// set and append write in the exec state; get reads the ram, then captures the
// word; insert and delete shift entries, if any, one per cycle through the ram
// ports, then write the gap or shorten the list; next request taken the cycle
// after the response is loaded; reset clears length, capacity to 256
// depends on ale_pkg, ale_ctrl, ale_dp and ale_ram; ram contents are not cleared
module array_list_engine
	import ale_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ale_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

`ifndef SYNTH
	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
		else $error("failed request returned data");

	a_shift_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rd |-> (sts.opcode == OP_INSERT || sts.opcode == OP_DELETE))
		else $error("entry shift for an opcode that moves nothing");
`endif

endmodule

/* design/ale_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/ale_ctrl.sv */
// control state machine of the array list engine
// depends on ale_pkg; drives the datapath through dp_cmd_t
module ale_ctrl
	import ale_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	fsm_t state_q, state_d;
	logic rsp_valid_q;
	logic slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.status != ST_OK) begin
					state_d = S_RESP;
				end else begin
					case (sts.opcode)
						OP_GET:                state_d = S_GET;
						OP_INSERT, OP_DELETE:  state_d = sts.shift_need ? S_SHIFT : S_FINAL;
						default:               state_d = S_RESP;
					endcase
				end
			end
			S_SHIFT: begin
				if (sts.shift_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_FINAL;
			S_FINAL: state_d = S_RESP;
			S_GET:   state_d = S_CAP;
			S_CAP:   state_d = S_RESP;
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.status == ST_OK) begin
					case (sts.opcode)
						OP_SET: cmd.wr_val = 1'b1;
						OP_APPEND: begin
							cmd.wr_val    = 1'b1;
							cmd.wr_at_len = 1'b1;
							cmd.len_inc   = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: cmd.shift_rd = 1'b1;
			S_FINAL: begin
				// insert drops the new value into the gap, delete just shortens
				if (sts.opcode == OP_INSERT) begin
					cmd.wr_val  = 1'b1;
					cmd.len_inc = 1'b1;
				end else begin
					cmd.len_dec = 1'b1;
				end
			end
			S_GET:  cmd.get_rd   = 1'b1;
			S_CAP:  cmd.get_cap  = 1'b1;
			S_RESP: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* design/ale_dp.sv */
// datapath of the array list engine: request, length, capacity, shift pipe
// depends on ale_pkg and ale_ram; commanded by ale_ctrl
module ale_dp
	import ale_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output rsp_t             rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [31:0] DEPTH_W = 32'(DEPTH);

	req_t                     req_q;
	rsp_t                     rsp_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         cap_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] rdv_q;
	logic [LEN_W-1:0]         rd_idx_q;
	logic [LEN_W-1:0]         wr_idx_s1;
	logic                     wr_pend_s1;

	logic [LEN_W-1:0]  pos_ext;
	logic [LEN_W-1:0]  pos_inc;
	logic              room;
	logic              pos_lt_len;
	logic              is_ins;
	status_t           status_c;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign pos_ext    = {1'b0, req_q.position};
	assign pos_inc    = pos_ext + 9'd1;
	assign pos_lt_len = pos_ext < len_q;
	assign room       = (len_q < cap_q) && (32'(len_q) < DEPTH_W);
	assign is_ins     = req_q.opcode == OP_INSERT;

	always_comb begin
		status_c = ST_OK;
		case (req_q.opcode)
			OP_GET, OP_SET, OP_DELETE: status_c = pos_lt_len ? ST_OK : ST_BOUNDS;
			OP_APPEND:                 status_c = room ? ST_OK : ST_FULL;
			OP_INSERT: begin
				// room is checked before the position
				if (!room) begin
					status_c = ST_FULL;
				end else if (pos_ext > len_q) begin
					status_c = ST_BOUNDS;
				end
			end
			default: status_c = ST_OK;
		endcase
	end

	assign sts.opcode     = req_q.opcode;
	assign sts.status     = status_c;
	assign sts.shift_need = is_ins ? (pos_ext != len_q) : (pos_inc != len_q);
	assign sts.shift_last = is_ins ? (rd_idx_q == pos_ext) : (rd_idx_q == len_q - 9'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			cap_q      <= CAP_RESET;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.shift_rd;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.len_inc) begin
				len_q <= len_q + 9'd1;
			end else if (cmd.len_dec) begin
				len_q <= len_q - 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			status_q <= status_c;
			rdv_q    <= '0;
			// insert walks down from the top, delete walks up from above the gap
			rd_idx_q <= is_ins ? len_q - 9'd1 : pos_inc;
		end
		if (cmd.shift_rd) begin
			rd_idx_q  <= is_ins ? rd_idx_q - 9'd1 : rd_idx_q + 9'd1;
			wr_idx_s1 <= is_ins ? rd_idx_q + 9'd1 : rd_idx_q - 9'd1;
		end
		if (cmd.get_cap) begin
			rdv_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			rsp_q.read_value <= rdv_q;
			rsp_q.status     <= status_q;
			rsp_q.length_now <= len_q;
		end
	end

	always_comb begin
		ram_we    = wr_pend_s1 || cmd.wr_val;
		ram_wdata = wr_pend_s1 ? ram_rdata : req_q.value;
		if (wr_pend_s1) begin
			ram_waddr = AW'(wr_idx_s1);
		end else if (cmd.wr_at_len) begin
			ram_waddr = AW'(len_q);
		end else begin
			ram_waddr = AW'(pos_ext);
		end
		ram_re    = cmd.shift_rd || cmd.get_rd;
		ram_raddr = cmd.shift_rd ? AW'(rd_idx_q) : AW'(pos_ext);
	end

	ale_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp = rsp_q;

endmodule
